// ===== rtl/core/mep_pkg.sv =====
// shared types, constants and helpers of the escape-time pixel block
package mep_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 12;
    localparam int CW         = 32;            // Q4.28 coordinate width
    localparam int ZW         = 40;            // Q12.28 internal width
    localparam int PW         = COORD_BITS + 31; // coordinate offset product width
    localparam int SW         = PW + 2;        // offset sum width
    localparam int MW         = FRAC_BITS + 2; // magnitude width after bound test

    localparam logic signed [SW-1:0] C_MAX = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] C_MIN = -SW'(64'sd1 <<< (CW - 1));
    localparam logic signed [ZW-1:0] Z_TWO = ZW'(64'sd2 <<< FRAC_BITS);
    localparam logic [MW+2:0]        R_FOUR = (MW+3)'(64'd4 << FRAC_BITS);

    typedef enum logic [2:0] {
        CFG_MIN_X    = 3'd0,
        CFG_MAX_Y    = 3'd1,
        CFG_X_STEP   = 3'd2,
        CFG_Y_STEP   = 3'd3,
        CFG_MAX_ITER = 3'd4,
        CFG_MODE     = 3'd5,
        CFG_PALETTE  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CW-1:0] min_x;
        logic signed [CW-1:0] max_y;
        logic [30:0]          x_step;
        logic [30:0]          y_step;
        logic [15:0]          max_iter;
        logic                 color_mode;
        logic [15:0]          palette_size;
    } t_cfg;

    typedef struct packed {
        logic signed [CW-1:0] re;
        logic signed [CW-1:0] im;
    } t_point;

    typedef struct packed {
        logic        inside_set;
        logic [15:0] iterations;
        logic [16:0] color;
    } t_result;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > C_MAX) begin
            r = C_MAX[CW-1:0];
        end else if (v < C_MIN) begin
            r = C_MIN[CW-1:0];
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/manowar_escape_time_pixel_top.sv =====
// top level of the escape-time pixel block
// Each iteration of the map goes through the states ST_TEST (the bound test
// and the three squaring products) and ST_SUM (the sums and the |z|^2 > 4
// test). Pixels are worked on one at a time by the engine; the front end and
// a two-entry point queue keep taking pixels while it runs, and a finished
// result waits in an output register.
module manowar_escape_time_pixel_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    output logic        empty,
    input  logic        pop,
    output logic        o_inside_set,
    output logic [15:0] o_iterations,
    output logic [16:0] o_color,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    mep_pkg::t_cfg    r_cfg;
    mep_pkg::t_point  w_fc, w_qc;
    logic             w_fc_v, w_fc_rdy, w_qc_v, w_qc_pop, w_res_v;
    mep_pkg::t_result w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_x        <= -32'sd536870912;
            r_cfg.max_y        <= 32'sd402653184;
            r_cfg.x_step       <= 31'd786432;
            r_cfg.y_step       <= 31'd786432;
            r_cfg.max_iter     <= 16'd256;
            r_cfg.color_mode   <= 1'b0;
            r_cfg.palette_size <= 16'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mep_pkg::CFG_MIN_X:    r_cfg.min_x        <= i_cfg_data;
                mep_pkg::CFG_MAX_Y:    r_cfg.max_y        <= i_cfg_data;
                mep_pkg::CFG_X_STEP:   r_cfg.x_step       <= i_cfg_data[30:0];
                mep_pkg::CFG_Y_STEP:   r_cfg.y_step       <= i_cfg_data[30:0];
                mep_pkg::CFG_MAX_ITER: r_cfg.max_iter     <= i_cfg_data[15:0];
                mep_pkg::CFG_MODE:     r_cfg.color_mode   <= i_cfg_data[0];
                mep_pkg::CFG_PALETTE:  r_cfg.palette_size <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    mep_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_cfg     (r_cfg),
        .o_c       (w_fc),
        .o_c_valid (w_fc_v),
        .i_c_ready (w_fc_rdy)
    );

    mep_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (w_fc),
        .i_wr    (w_fc_v),
        .o_ready (w_fc_rdy),
        .o_data  (w_qc),
        .o_valid (w_qc_v),
        .i_rd    (w_qc_pop)
    );

    mep_iter u_iter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_c         (w_qc),
        .i_c_valid   (w_qc_v),
        .o_c_pop     (w_qc_pop),
        .o_res       (w_res),
        .o_res_valid (w_res_v),
        .i_res_pop   (pop)
    );

    assign empty        = !w_res_v;
    assign o_inside_set = w_res.inside_set;
    assign o_iterations = w_res.iterations;
    assign o_color      = w_res.color;
endmodule

// ===== rtl/core/mep_front.sv =====
// front end: forms the point c of each accepted pixel
module mep_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [11:0]          i_pixel_x,
    input  logic [11:0]          i_pixel_y,
    input  mep_pkg::t_cfg        i_cfg,
    output mep_pkg::t_point      o_c,
    output logic                 o_c_valid,
    input  logic                 i_c_ready
);
    logic                      r_v;
    logic [mep_pkg::PW-1:0]    r_px_prod;
    logic [mep_pkg::PW-1:0]    r_py_prod;
    logic                      n_v;
    logic                      w_take;
    logic signed [mep_pkg::SW-1:0] w_re;
    logic signed [mep_pkg::SW-1:0] w_im;

    assign full   = r_v && !i_c_ready;
    assign w_take = push && !full;
    assign n_v    = w_take ? 1'b1 : (i_c_ready ? 1'b0 : r_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_px_prod <= mep_pkg::PW'(i_pixel_x) * mep_pkg::PW'(i_cfg.x_step);
            r_py_prod <= mep_pkg::PW'(i_pixel_y) * mep_pkg::PW'(i_cfg.y_step);
        end
    end

    assign w_re = mep_pkg::SW'(i_cfg.min_x) + $signed({2'b00, r_px_prod});
    assign w_im = mep_pkg::SW'(i_cfg.max_y) - $signed({2'b00, r_py_prod});

    assign o_c.re    = mep_pkg::sat_coord(w_re);
    assign o_c.im    = mep_pkg::sat_coord(w_im);
    assign o_c_valid = r_v;
endmodule

// ===== rtl/core/mep_fifo.sv =====
// two-entry point queue between front end and iteration engine
module mep_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mep_pkg::t_point i_data,
    input  logic            i_wr,
    output logic            o_ready,
    output mep_pkg::t_point o_data,
    output logic            o_valid,
    input  logic            i_rd
);
    mep_pkg::t_point r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            w_wr;
    logic            w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_wr && o_ready;
    assign w_rd    = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ===== rtl/core/mep_iter.sv =====
// iteration engine: runs the map for one point, holds the result register
module mep_iter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mep_pkg::t_cfg    i_cfg,
    input  mep_pkg::t_point  i_c,
    input  logic             i_c_valid,
    output logic             o_c_pop,
    output mep_pkg::t_result o_res,
    output logic             o_res_valid,
    input  logic             i_res_pop
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TEST = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    localparam int ZW = mep_pkg::ZW;
    localparam int MW = mep_pkg::MW;
    localparam int FB = mep_pkg::FRAC_BITS;

    t_state                  r_state;
    logic signed [ZW-1:0]    r_cre, r_cim, r_zre, r_zim, r_mre, r_mim;
    logic [15:0]             r_n;
    logic                    r_inside;
    logic [MW:0]             r_re2, r_im2;
    logic [MW+1:0]           r_prod;
    logic                    r_neg;
    logic                    r_out_v;
    mep_pkg::t_result        r_out;

    logic signed [ZW-1:0]    w_are, w_aim;
    logic [MW-1:0]           w_mre, w_mim;
    logic [2*MW-1:0]         w_sq_re, w_sq_im, w_pr;
    logic                    w_big;
    logic [MW+2:0]           w_r2;
    logic signed [ZW-1:0]    w_nre, w_nim, w_p;
    logic                    w_out_free;
    logic [16:0]             w_off, w_pal;
    logic [17:0]             w_pal3;

    assign w_are   = r_zre[ZW-1] ? -r_zre : r_zre;
    assign w_aim   = r_zim[ZW-1] ? -r_zim : r_zim;
    assign w_mre   = w_are[MW-1:0];
    assign w_mim   = w_aim[MW-1:0];
    assign w_sq_re = w_mre * w_mre;
    assign w_sq_im = w_mim * w_mim;
    assign w_pr    = w_mre * w_mim;
    assign w_big   = (r_zre > mep_pkg::Z_TWO) || (r_zre < -mep_pkg::Z_TWO)
                  || (r_zim > mep_pkg::Z_TWO) || (r_zim < -mep_pkg::Z_TWO);

    assign w_r2  = (MW+3)'(r_re2) + (MW+3)'(r_im2);
    assign w_p   = ZW'(r_prod);
    assign w_nre = ZW'(r_re2) - ZW'(r_im2) + r_cre + r_mre;
    assign w_nim = (r_neg ? -w_p : w_p) + r_cim + r_mim;

    // quadrant offset for escape-angle colouring
    assign w_pal  = 17'(i_cfg.palette_size);
    assign w_pal3 = 18'(w_pal) + 18'({w_pal, 1'b0});
    always_comb begin
        if (r_zre > 0 && r_zim > 0) begin
            w_off = 17'd1;
        end else if (r_zre <= 0 && r_zim > 0) begin
            w_off = w_pal >> 2;
        end else if (r_zre <= 0 && r_zim < 0) begin
            w_off = w_pal >> 1;
        end else begin
            w_off = {1'b0, w_pal3[17:2]};
        end
    end

    assign w_out_free  = !r_out_v || i_res_pop;
    assign o_c_pop     = (r_state == ST_IDLE) && i_c_valid;
    assign o_res       = r_out;
    assign o_res_valid = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
        end else begin
            if (r_state == ST_DONE && w_out_free) begin
                r_out_v <= 1'b1;
            end else if (i_res_pop) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_c_valid) begin
                        r_state <= ST_TEST;
                    end
                end
                ST_TEST: begin
                    if (r_n == i_cfg.max_iter || w_big) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (w_r2 > mep_pkg::R_FOUR) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_TEST;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cre    <= ZW'(i_c.re);
                r_cim    <= ZW'(i_c.im);
                r_zre    <= ZW'(i_c.re);
                r_zim    <= ZW'(i_c.im);
                r_mre    <= ZW'(i_c.re);
                r_mim    <= ZW'(i_c.im);
                r_n      <= '0;
                r_inside <= 1'b1;
            end
            ST_TEST: begin
                if (r_n != i_cfg.max_iter && w_big) begin
                    r_inside <= 1'b0;
                end
                r_re2  <= w_sq_re[2*MW-2:FB];
                r_im2  <= w_sq_im[2*MW-2:FB];
                r_prod <= (MW+2)'(w_pr >> (FB - 1));
                r_neg  <= r_zre[ZW-1] ^ r_zim[ZW-1];
            end
            ST_SUM: begin
                if (w_r2 > mep_pkg::R_FOUR) begin
                    r_inside <= 1'b0;
                end else begin
                    r_mre <= r_zre;
                    r_mim <= r_zim;
                    r_zre <= w_nre;
                    r_zim <= w_nim;
                    r_n   <= r_n + 16'd1;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out.inside_set <= r_inside;
                    r_out.iterations <= r_n;
                    r_out.color      <= i_cfg.color_mode ? 17'(r_n) + w_off : 17'(r_n);
                end
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/core/mep_checker.sv =====
// port-level checks of the escape-time pixel block, bound to the top level
module mep_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        o_inside_set,
    input logic [15:0] o_iterations,
    input logic [16:0] o_color
);
    // nothing waits right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("result or full flag shown after reset");

    // a waiting result that is not taken holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_iterations) && $stable(o_color)
                           && $stable(o_inside_set))
        else $error("waiting result changed");

    // colour is the count plus a nonnegative offset
    a_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> {1'b0, o_iterations} <= o_color)
        else $error("colour below iteration count");
endmodule

bind manowar_escape_time_pixel_top mep_checker u_mep_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_inside_set (o_inside_set),
    .o_iterations (o_iterations),
    .o_color      (o_color)
);

// ===== tb/manowar_escape_time_pixel_top_tb.sv =====
// testbench of the escape-time pixel block: scoreboard with its own predictor, random traffic
module manowar_escape_time_pixel_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    class pixel_scoreboard;
        longint min_x, max_y, x_step, y_step;
        int unsigned max_iter, palette_size;
        bit color_mode;
        mep_pkg::t_result pending_q[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned inside_seen;

        function void reset_regs();
            min_x = -536870912;
            max_y = 402653184;
            x_step = 786432;
            y_step = 786432;
            max_iter = 256;
            color_mode = 0;
            palette_size = 256;
        endfunction

        function void write_reg(mep_pkg::t_cfg_idx idx, logic [31:0] d);
            case (idx)
                mep_pkg::CFG_MIN_X:    min_x = longint'(signed'(d));
                mep_pkg::CFG_MAX_Y:    max_y = longint'(signed'(d));
                mep_pkg::CFG_X_STEP:   x_step = longint'(d[30:0]);
                mep_pkg::CFG_Y_STEP:   y_step = longint'(d[30:0]);
                mep_pkg::CFG_MAX_ITER: max_iter = d[15:0];
                mep_pkg::CFG_MODE:     color_mode = d[0];
                mep_pkg::CFG_PALETTE:  palette_size = d[15:0];
                default: ;
            endcase
        endfunction

        // product shifted right, truncated toward zero
        function longint scaled_mul(longint a, longint b, int s);
            longint ma, mb, p;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            p = (ma * mb) >>> s;
            return ((a < 0) != (b < 0)) ? -p : p;
        endfunction

        function longint clamp_coord(longint v);
            longint hi, lo;
            hi = (64'sd1 <<< 31) - 1;
            lo = -(64'sd1 <<< 31);
            return (v > hi) ? hi : ((v < lo) ? lo : v);
        endfunction

        function void note_pixel(logic [11:0] px, logic [11:0] py);
            longint c_re, c_im, z_re, z_im, m_re, m_im, re2, im2, nre, nim, two, four;
            int unsigned n, off;
            bit in_set;
            mep_pkg::t_result r;
            two = 64'sd2 <<< mep_pkg::FRAC_BITS;
            four = 64'sd4 <<< mep_pkg::FRAC_BITS;
            c_re = clamp_coord(min_x + longint'(px) * x_step);
            c_im = clamp_coord(max_y - longint'(py) * y_step);
            z_re = c_re; z_im = c_im; m_re = c_re; m_im = c_im;
            in_set = 1;
            for (n = 0; n < max_iter; n++) begin
                if (z_re > two || z_re < -two || z_im > two || z_im < -two) begin
                    in_set = 0;
                    break;
                end
                re2 = scaled_mul(z_re, z_re, mep_pkg::FRAC_BITS);
                im2 = scaled_mul(z_im, z_im, mep_pkg::FRAC_BITS);
                if (re2 + im2 > four) begin
                    in_set = 0;
                    break;
                end
                nim = scaled_mul(z_re, z_im, mep_pkg::FRAC_BITS - 1) + c_im + m_im;
                nre = re2 - im2 + c_re + m_re;
                m_re = z_re; m_im = z_im;
                z_re = nre; z_im = nim;
            end
            off = 0;
            if (color_mode) begin
                if (z_re > 0 && z_im > 0) off = 1;
                else if (z_re <= 0 && z_im > 0) off = palette_size >> 2;
                else if (z_re <= 0 && z_im < 0) off = palette_size >> 1;
                else off = (3 * palette_size) >> 2;
            end
            r.inside_set = in_set;
            r.iterations = n[15:0];
            r.color = 17'(n + off);
            pending_q.push_back(r);
        endfunction

        function void check_result(logic ins, logic [15:0] iters, logic [16:0] col);
            mep_pkg::t_result e;
            checked++;
            if (pending_q.size() == 0) begin
                $error("result with no pixel outstanding: inside_set=%0d iterations=%0d color=%0d",
                       ins, iters, col);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (e.inside_set) inside_seen++;
            if (ins !== e.inside_set) begin
                $error("inside_set: expected %0d, got %0d", e.inside_set, ins);
                errors++;
            end
            if (iters !== e.iterations) begin
                $error("iterations: expected %0d, got %0d", e.iterations, iters);
                errors++;
            end
            if (col !== e.color) begin
                $error("color: expected %0d, got %0d", e.color, col);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [11:0] i_pixel_x = '0;
    logic [11:0] i_pixel_y = '0;
    logic        empty;
    logic        pop = 0;
    logic        o_inside_set;
    logic [15:0] o_iterations;
    logic [16:0] o_color;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    pixel_scoreboard sb = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_off_cycles = 0;
    int unsigned pixels_sent = 0;

    manowar_escape_time_pixel_top u_top (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    // result side: random pop, plus one long hold-off on request
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off_cycles != 0) begin
                pop <= 0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge i_clk);
            if (pop && !empty) sb.check_result(o_inside_set, o_iterations, o_color);
        end
    end

    task automatic send_pixel(logic [11:0] px, logic [11:0] py);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push <= 1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        do @(posedge i_clk); while (full);
        sb.note_pixel(px, py);
        pixels_sent++;
    endtask

    task automatic write_reg(mep_pkg::t_cfg_idx idx, logic [31:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic set_view(logic [31:0] mx, logic [31:0] my, logic [30:0] xs, logic [30:0] ys,
                            logic [15:0] mi, logic md, logic [15:0] pal);
        push <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        write_reg(mep_pkg::CFG_MIN_X, mx);
        write_reg(mep_pkg::CFG_MAX_Y, my);
        write_reg(mep_pkg::CFG_X_STEP, {1'b0, xs});
        write_reg(mep_pkg::CFG_Y_STEP, {1'b0, ys});
        write_reg(mep_pkg::CFG_MAX_ITER, {16'd0, mi});
        write_reg(mep_pkg::CFG_MODE, {31'd0, md});
        write_reg(mep_pkg::CFG_PALETTE, {16'd0, pal});
    endtask

    initial begin
        logic [15:0] iter_choice [6] = '{16'd1, 16'd7, 16'd32, 16'd64, 16'd100, 16'd0};
        logic [15:0] pal_choice [6] = '{16'd0, 16'd1, 16'd65535, 16'd256, 16'd3, 16'd0};
        logic [11:0] px, py;
        sb.reset_regs();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // after-reset view: corners, a point near the origin (inside), a few others
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd683, 12'd512);
        send_pixel(12'd600, 12'd400);
        send_pixel(12'd500, 12'd512);
        // angle colours, zero palette, zero iteration limit
        set_view(32'hE000_0000, 32'h1800_0000, 31'd786432, 31'd786432, 16'd20, 1'b1, 16'd0);
        send_pixel(12'd683, 12'd512);
        send_pixel(12'd620, 12'd450);
        send_pixel(12'd700, 12'd600);
        set_view(32'hE000_0000, 32'h1800_0000, 31'd786432, 31'd786432, 16'd0, 1'b1, 16'd65535);
        send_pixel(12'd683, 12'd512);
        send_pixel(12'd4095, 12'd4095);
        // saturated coordinates at both ends
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd1, 1'b1, 16'd1);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 31'd0, 16'd65535, 1'b0, 16'd256);
        send_pixel(12'd1, 12'd1);
        // c = 0 stays inside for the full 16-bit iteration limit
        set_view(32'h0, 32'h0, 31'd0, 31'd0, 16'd65535, 1'b1, 16'd65535);
        send_pixel(12'd4095, 12'd0);

        for (int ph = 0; ph < 6; ph++) begin
            set_view(32'($urandom_range(0, 402653184)) - 32'd671088640,
                     32'($urandom_range(0, 402653184)),
                     31'($urandom_range(1 << 16, 1 << 20)),
                     31'($urandom_range(1 << 16, 1 << 20)),
                     (ph == 5) ? 16'($urandom_range(1, 128)) : iter_choice[ph],
                     ph[0],
                     (ph == 5) ? 16'($urandom) : pal_choice[ph]);
            send_idle_pct = (ph < 2) ? 22 : ((ph < 4) ? 63 : 0);
            recv_idle_pct = (ph < 2) ? 63 : ((ph < 4) ? 22 : 0);
            if (ph == 0) hold_off_cycles = 400;
            for (int k = 0; k < 250; k++) begin
                if ($urandom_range(99) < 80) begin
                    px = 12'($urandom_range(0, 1023));
                    py = 12'($urandom_range(0, 1023));
                end else begin
                    px = 12'($urandom);
                    py = 12'($urandom);
                end
                send_pixel(px, py);
            end
        end
        push <= 0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("pixels sent: %0d, results checked: %0d, inside the set: %0d",
                 pixels_sent, sb.checked, sb.inside_seen);
        $display("views: reset, saturated, zero limit, full limit, six random, both colour modes");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
